/* hdl/id3tte_pkg.sv */
`timescale 1ns / 1ps

package id3tte_pkg;

   // byte window and text field limits
   localparam int WINDOW_BYTES = 4096;
   localparam int POS_W        = $clog2(WINDOW_BYTES + 1);
   localparam int TEXT_LEN     = 32;
   localparam int TEXT_IDX_W   = $clog2(TEXT_LEN);
   localparam logic [TEXT_IDX_W-1:0] TEXT_MAX = TEXT_IDX_W'(TEXT_LEN - 1);

   // frame header geometry
   localparam int HDR_DEPTH = 10;
   localparam int HDR_IDX_W = $clog2(HDR_DEPTH);
   localparam logic [3:0] HDR_LEN_LONG  = 4'd10;
   localparam logic [3:0] HDR_LEN_SHORT = 4'd6;
   localparam logic [7:0] VERSION_LONG_HDR = 8'd3;

   // tag start offsets
   localparam logic [POS_W-1:0] TAG_HDR_END  = POS_W'(9);
   localparam logic [POS_W-1:0] FIRST_FRAME  = POS_W'(10);

   // identifiers
   localparam logic [23:0] ID_ID3  = "ID3";
   localparam logic [23:0] ID_TT2  = "TT2";
   localparam logic [31:0] ID_TIT2 = "TIT2";
   localparam logic [23:0] ID_TP1  = "TP1";
   localparam logic [31:0] ID_TPE1 = "TPE1";
   localparam logic [23:0] ID_TAL  = "TAL";

   // result kinds
   localparam logic [1:0] KIND_TEXT   = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_NOTAG  = 2'd2;

   // text targets
   localparam logic [1:0] FIELD_TITLE  = 2'd0;
   localparam logic [1:0] FIELD_ARTIST = 2'd1;
   localparam logic [1:0] FIELD_ALBUM  = 2'd2;
   localparam logic [1:0] FIELD_NONE   = 2'd3;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [1:0]  text_field;
      logic [4:0]  char_index;
      logic [7:0]  char_value;
      logic [27:0] audio_start;
      logic [7:0]  tag_version;
   } result_type;

endpackage

/* hdl/id3tte_if.sv */
`timescale 1ns / 1ps

// input byte channel
interface id3tte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// result channel
interface id3tte_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [1:0]  text_field;
   logic [4:0]  char_index;
   logic [7:0]  char_value;
   logic [27:0] audio_start;
   logic [7:0]  tag_version;

   modport source (output valid, output result_kind, output text_field, output char_index,
                   output char_value, output audio_start, output tag_version, input ready);
   modport sink   (input valid, input result_kind, input text_field, input char_index,
                   input char_value, input audio_start, input tag_version, output ready);
endinterface

/* hdl/id3v2_tag_text_extractor_core.sv */
`timescale 1ns / 1ps

// channel   dir   payload                                              role
// req_if    in    data_byte, first_byte                                file bytes from offset 0
// rsp_if    out   result_kind, text_field, char_index, char_value,     header, no-tag and
//                 audio_start, tag_version                             text character results
//
// one byte is taken per cycle while req_if.ready is high; its result is registered in the output slot, or in the skid
// slot while the output slot waits. the byte decode (tag header, frame header collector, text emitter) is a single pass
// of logic. two result slots (output register plus skid) keep req_if.ready high while one result waits
// req_if.ready drops only when both slots are full
// reset is synchronous and returns the parser to the tag header at offset 0

module id3v2_tag_text_extractor_core
   import id3tte_pkg::*;
(
   input  logic clock,
   input  logic reset,
   id3tte_req_if.sink   req_if,
   id3tte_rsp_if.source rsp_if
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_NOTAG,
      PH_WALK,
      PH_DONE
   } phase_type;

   // parse state
   phase_type              phase_ff, phase_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [7:0]             version_ff, version_in;
   logic [27:0]            tag_len_ff, tag_len_in;
   logic [7:0]             hdr_ff [HDR_DEPTH];
   logic [7:0]             hdr_in [HDR_DEPTH];
   logic [POS_W-1:0]       frame_pos_ff, frame_pos_in;
   logic [1:0]             target_ff, target_in;
   logic [TEXT_IDX_W-1:0]  count_ff, count_in;
   logic [TEXT_IDX_W-1:0]  limit_ff, limit_in;
   logic                   skip_ff, skip_in;

   // result slots
   result_type out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;
   result_type res;
   logic       produce;
   logic       accept;
   logic       pop;

   // decode helpers
   logic [POS_W-1:0]  cur_pos;
   phase_type         cur_phase;
   logic [1:0]        cur_target;
   logic [7:0]        b;
   logic [POS_W-1:0]  idx;
   logic [3:0]        hl;
   logic [31:0]       fsize;
   logic [1:0]        tgt;
   logic [TEXT_IDX_W-1:0] lim;
   logic [POS_W+1:0]  next_start;

   function automatic logic [POS_W-1:0] walk_limit(input logic [27:0] tl);
      if (tl < 28'(WINDOW_BYTES)) begin
         return tl[POS_W-1:0];
      end
      return POS_W'(WINDOW_BYTES);
   endfunction

   assign accept       = req_if.valid && req_if.ready;
   assign pop          = out_valid_ff && rsp_if.ready;
   assign req_if.ready = !skid_valid_ff;
   assign b            = req_if.data_byte;

   // byte decode
   always_comb begin
      cur_pos    = req_if.first_byte ? '0 : pos_ff;
      cur_phase  = req_if.first_byte ? PH_HEADER : phase_ff;
      cur_target = req_if.first_byte ? FIELD_NONE : target_ff;

      phase_in     = cur_phase;
      pos_in       = cur_pos;
      version_in   = version_ff;
      tag_len_in   = tag_len_ff;
      hdr_in       = hdr_ff;
      frame_pos_in = frame_pos_ff;
      target_in    = cur_target;
      count_in     = count_ff;
      limit_in     = limit_ff;
      skip_in      = skip_ff;
      produce      = 1'b0;
      res          = '0;
      idx          = cur_pos - frame_pos_ff;
      hl           = (version_ff >= VERSION_LONG_HDR) ? HDR_LEN_LONG : HDR_LEN_SHORT;
      fsize        = (hl == HDR_LEN_LONG) ? {hdr_ff[4], hdr_ff[5], hdr_ff[6], hdr_ff[7]}
                                          : {8'd0, hdr_ff[3], hdr_ff[4], b};
      next_start   = (POS_W+2)'(frame_pos_ff) + (POS_W+2)'(fsize[POS_W-1:0])
                     + (POS_W+2)'(hl);

      // frame id match
      if ({hdr_ff[0], hdr_ff[1], hdr_ff[2]} == ID_TT2 ||
          {hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3]} == ID_TIT2) begin
         tgt = FIELD_TITLE;
      end else if ({hdr_ff[0], hdr_ff[1], hdr_ff[2]} == ID_TP1 ||
                   {hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3]} == ID_TPE1) begin
         tgt = FIELD_ARTIST;
      end else if ({hdr_ff[0], hdr_ff[1], hdr_ff[2]} == ID_TAL) begin
         tgt = FIELD_ALBUM;
      end else begin
         tgt = FIELD_NONE;
      end

      // text length: frame size less the encoding byte, at most TEXT_MAX (also for size zero)
      if (fsize == 32'd0 || fsize > 32'(TEXT_LEN)) begin
         lim = TEXT_MAX;
      end else begin
         lim = TEXT_IDX_W'(fsize - 32'd1);
      end

      if (cur_pos < POS_W'(WINDOW_BYTES)) begin
         pos_in = cur_pos + POS_W'(1);
         case (cur_phase)
            PH_HEADER: begin
               if (cur_pos < POS_W'(3)) begin
                  hdr_in[HDR_IDX_W'(cur_pos[1:0])] = b;
                  if (cur_pos == POS_W'(2) && {hdr_ff[0], hdr_ff[1], b} != ID_ID3) begin
                     phase_in        = PH_NOTAG;
                     produce         = 1'b1;
                     res.result_kind = KIND_NOTAG;
                  end
               end else if (cur_pos == POS_W'(3)) begin
                  version_in = b;
               end else if (cur_pos >= POS_W'(6) && cur_pos <= TAG_HDR_END) begin
                  tag_len_in = {tag_len_ff[20:0], b[6:0]};
                  if (cur_pos == TAG_HDR_END) begin
                     produce         = 1'b1;
                     res.result_kind = KIND_HEADER;
                     res.audio_start = tag_len_in;
                     res.tag_version = version_ff;
                     frame_pos_in    = FIRST_FRAME;
                     phase_in        = (FIRST_FRAME < walk_limit(tag_len_in)) ? PH_WALK
                                                                               : PH_DONE;
                  end
               end
            end
            PH_WALK, PH_DONE: begin
               // text emitter of the frame found earlier
               if (cur_target != FIELD_NONE) begin
                  if (skip_ff) begin
                     skip_in = 1'b0;
                  end else if (b == 8'd0 || count_ff >= limit_ff) begin
                     target_in = FIELD_NONE;
                  end else begin
                     produce         = 1'b1;
                     res.result_kind = KIND_TEXT;
                     res.text_field  = cur_target;
                     res.char_index  = 5'(count_ff);
                     res.char_value  = b;
                     count_in        = count_ff + TEXT_IDX_W'(1);
                     if (count_in >= limit_ff) begin
                        target_in = FIELD_NONE;
                     end
                  end
               end
               // frame header collector
               if (cur_phase == PH_WALK && cur_pos >= frame_pos_ff &&
                   idx < POS_W'(hl)) begin
                  hdr_in[HDR_IDX_W'(idx)] = b;
                  if (idx == POS_W'(hl - 4'd1)) begin
                     if (tgt != FIELD_NONE) begin
                        count_in  = '0;
                        limit_in  = lim;
                        skip_in   = 1'b1;
                        target_in = (lim == '0) ? FIELD_NONE : tgt;
                     end
                     frame_pos_in = next_start[POS_W-1:0];
                     if (fsize[31:POS_W] != '0 ||
                         next_start >= (POS_W+2)'(walk_limit(tag_len_ff))) begin
                        phase_in = PH_DONE;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state and result slots
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         version_ff    <= '0;
         tag_len_ff    <= '0;
         frame_pos_ff  <= FIRST_FRAME;
         target_ff     <= FIELD_NONE;
         count_ff      <= '0;
         limit_ff      <= '0;
         skip_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            pos_ff       <= pos_in;
            version_ff   <= version_in;
            tag_len_ff   <= tag_len_in;
            frame_pos_ff <= frame_pos_in;
            target_ff    <= target_in;
            count_ff     <= count_in;
            limit_ff     <= limit_in;
            skip_ff      <= skip_in;
         end
         if (!out_valid_ff || pop) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept && produce;
            end
         end else if (accept && produce) begin
            skid_valid_ff <= 1'b1;
         end
      end
      // payload registers
      if (accept) begin
         hdr_ff <= hdr_in;
      end
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (accept && produce) begin
         skid_ff <= res;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.result_kind = out_ff.result_kind;
   assign rsp_if.text_field  = out_ff.text_field;
   assign rsp_if.char_index  = out_ff.char_index;
   assign rsp_if.char_value  = out_ff.char_value;
   assign rsp_if.audio_start = out_ff.audio_start;
   assign rsp_if.tag_version = out_ff.tag_version;

`ifndef SYNTHESIS
   // the skid slot only fills behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full while output slot empty");

   // a walking parser always has its next frame inside the walk range
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WALK |-> frame_pos_ff < walk_limit(tag_len_ff))
      else $error("frame start beyond walk limit while walking");

   // an active text emitter has characters left
   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      target_ff != FIELD_NONE |-> count_ff < limit_ff)
      else $error("text emitter active with no characters left");

   // character index never reaches TEXT_MAX, one below the field length
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.result_kind == KIND_TEXT |-> out_ff.char_index != TEXT_MAX)
      else $error("text character index out of range");

   // a transfer that yields a result leaves the output slot valid in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept && produce |=> out_valid_ff)
      else $error("result lost after input transfer");
`endif

endmodule
